@@ design/lbkl_pkg.sv @@
package lbkl_pkg;

  // field and datapath widths
  localparam int DVD_W      = 16;
  localparam int DVS_W      = 8;
  localparam int DUTY_W     = 8;
  localparam int COUNT_W    = 16;
  localparam int HOLD_W     = 10;
  localparam int LEVEL_W    = 5;
  localparam int IDLE_W     = 15;
  localparam int MODE_W     = 2;
  localparam int RATE_W     = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  // key-press level scale
  localparam int LEVEL_MAX  = 20;
  localparam int LEVEL_STEP = 255 / LEVEL_MAX;

  localparam logic [IDLE_W-1:0]  IDLE_LIMIT  = IDLE_W'(1000);
  localparam logic [HOLD_W-1:0]  PRESS_HOLD  = HOLD_W'(511);
  localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(4);
  localparam logic [DUTY_W-1:0]  DUTY_FULL   = DUTY_W'(255);
  localparam logic [RATE_W-1:0]  BRIGHT_RST  = RATE_W'(10);
  localparam logic [RATE_W-1:0]  DIM_RST     = RATE_W'(4);

  typedef enum logic [MODE_W-1:0] {
    MODE_BREATHE      = 2'd0,
    MODE_IDLE_BREATHE = 2'd1,
    MODE_LEVEL        = 2'd2,
    MODE_OFF          = 2'd3
  } lbkl_mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MODE     = 2'd0,
    CFG_BRIGHTEN = 2'd1,
    CFG_DIM      = 2'd2
  } lbkl_cfg_idx_t;

  typedef enum logic [1:0] {
    PH_RAMP_UP   = 2'd0,
    PH_HOLD_HIGH = 2'd1,
    PH_RAMP_DOWN = 2'd2,
    PH_HOLD_LOW  = 2'd3
  } lbkl_phase_t;

  typedef enum logic {
    CMD_TICK = 1'b0,
    CMD_KEY  = 1'b1
  } lbkl_cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_UPDATE
  } lbkl_state_t;

  // divider request and response
  typedef struct packed {
    logic              start;
    logic [DVD_W-1:0]  dividend;
    logic [DVS_W-1:0]  divisor;
  } lbkl_div_req_t;

  typedef struct packed {
    logic              done;
    logic [DVD_W-1:0]  quotient;
  } lbkl_div_rsp_t;

endpackage

@@ design/lbkl_div.sv @@
module lbkl_div (
  input  logic                   clk,
  input  logic                   rst_n,
  input  lbkl_pkg::lbkl_div_req_t req,
  output lbkl_pkg::lbkl_div_rsp_t rsp
);

  localparam int DVD_W = lbkl_pkg::DVD_W;
  localparam int DVS_W = lbkl_pkg::DVS_W;
  localparam int CNT_W = $clog2(DVD_W);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DVD_W - 1);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DVS_W-1:0] rem_r, rem_nxt;
  logic [DVS_W-1:0] dvs_r, dvs_nxt;
  logic [DVD_W-1:0] quo_r, quo_nxt;

  logic [DVS_W:0]   trial;
  logic [DVS_W:0]   diff;
  logic             fits;

  // one restoring step: shift in the next dividend bit and try a subtract
  assign trial = {rem_r, quo_r[DVD_W-1]};
  assign diff  = trial - {1'b0, dvs_r};
  assign fits  = trial >= {1'b0, dvs_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    quo_nxt  = quo_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      dvs_nxt  = req.divisor;
      quo_nxt  = req.dividend;
    end else if (busy_r) begin
      rem_nxt = fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
      quo_nxt = {quo_r[DVD_W-2:0], fits};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_LAST) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
    quo_r <= quo_nxt;
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule

@@ design/led_breathing_and_keypress_level_top.sv @@
// Backlight PWM duty generator. Each input transaction is a one-millisecond tick or a key press
// and returns exactly one result transaction with the current duty and enable. Modes: breathing
// ramp, breathing once idle for over 1000 ms, key-press level with a 511-tick hold then decay,
// and off. Every transaction runs one pass of a shared 16-step restoring divider (ramp count
// by rate, level scaling, decay level), and the block takes no new item until it has loaded
// the divider, run the sixteen divide steps, collected the quotient, updated the state and
// presented the result. The result sits in an output register, so the next item is taken
// while a result waits; the state update stalls only if the previous result has not been
// taken by then. Configuration writes are taken every cycle and must only be issued while
// the block is idle.
module led_breathing_and_keypress_level_top (
  input  logic                              clk,
  input  logic                              rst_n,
  // configuration
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [lbkl_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [lbkl_pkg::CFG_DATA_W-1:0]   cfg_data,
  // input transactions
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_cmd,
  input  logic [lbkl_pkg::IDLE_W-1:0]       in_idle_ms,
  // result transactions
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [lbkl_pkg::DUTY_W-1:0]       out_pwm_duty,
  output logic                              out_pwm_enable
);

  localparam int DVD_W      = lbkl_pkg::DVD_W;
  localparam int DUTY_W     = lbkl_pkg::DUTY_W;
  localparam int COUNT_W    = lbkl_pkg::COUNT_W;
  localparam int HOLD_W     = lbkl_pkg::HOLD_W;
  localparam int LEVEL_W    = lbkl_pkg::LEVEL_W;
  localparam int RATE_W     = lbkl_pkg::RATE_W;
  localparam int DVS_W_SEL  = lbkl_pkg::DVS_W;
  localparam int MODE_W_SEL = lbkl_pkg::MODE_W;

  // configuration registers
  lbkl_pkg::lbkl_mode_t   mode_r;
  logic [RATE_W-1:0]      bright_r;
  logic [RATE_W-1:0]      dim_r;

  // block state
  lbkl_pkg::lbkl_state_t  state_r, state_nxt;
  lbkl_pkg::lbkl_phase_t  phase_r, phase_nxt;
  logic [COUNT_W-1:0]     count_r, count_nxt;
  logic [DUTY_W-1:0]      duty_r, duty_nxt;
  logic                   en_r, en_nxt;
  logic [HOLD_W-1:0]      hold_r, hold_nxt;
  logic [LEVEL_W-1:0]     level_r, level_nxt;
  logic [DUTY_W-1:0]      life_r, life_nxt;
  logic                   out_valid_r, out_valid_nxt;
  lbkl_pkg::lbkl_cmd_t    cmd_r, cmd_nxt;
  logic                   brth_r, brth_nxt;

  lbkl_pkg::lbkl_div_req_t div_req;
  lbkl_pkg::lbkl_div_rsp_t div_rsp;

  logic [RATE_W-1:0]      br_eff, dr_eff;
  logic [COUNT_W-1:0]     lim_br, lim_dr;
  logic [COUNT_W-1:0]     count_inc;
  logic                   tick_breathe;
  logic [LEVEL_W:0]       level_inc;
  logic [DVD_W-1:0]       op_dividend;
  logic [DVS_W_SEL-1:0]   op_divisor;
  logic [DVD_W-1:0]       quo;
  logic                   quo_hi;

  // a rate of zero acts as one
  assign br_eff = (bright_r == '0) ? RATE_W'(1) : bright_r;
  assign dr_eff = (dim_r == '0) ? RATE_W'(1) : dim_r;

  // 255 * rate as shift and subtract
  assign lim_br = COUNT_W'({br_eff, 8'h00}) - COUNT_W'(br_eff);
  assign lim_dr = COUNT_W'({dr_eff, 8'h00}) - COUNT_W'(dr_eff);

  // saturating ramp counter increment
  assign count_inc = (count_r == '1) ? count_r : count_r + 1'b1;

  assign tick_breathe = (lbkl_pkg::lbkl_cmd_t'(in_cmd) == lbkl_pkg::CMD_TICK) &&
                        ((mode_r == lbkl_pkg::MODE_BREATHE) ||
                         ((mode_r == lbkl_pkg::MODE_IDLE_BREATHE) &&
                          (in_idle_ms > lbkl_pkg::IDLE_LIMIT)));

  assign level_inc = {1'b0, level_r} + 1'b1;

  // divider operands for the arriving transaction
  always_comb begin
    if (lbkl_pkg::lbkl_cmd_t'(in_cmd) == lbkl_pkg::CMD_KEY) begin
      op_dividend = DVD_W'({level_inc, 8'h00}) - DVD_W'(level_inc);
      op_divisor  = DVS_W_SEL'(lbkl_pkg::LEVEL_MAX);
    end else if (tick_breathe) begin
      op_dividend = count_r;
      op_divisor  = (phase_r == lbkl_pkg::PH_RAMP_DOWN) ? dr_eff : br_eff;
    end else begin
      // decay: 255 minus the decremented life
      op_dividend = DVD_W'(256) - DVD_W'(life_r);
      op_divisor  = DVS_W_SEL'(lbkl_pkg::LEVEL_STEP);
    end
  end

  assign quo    = div_rsp.quotient;
  assign quo_hi = |quo[DVD_W-1:DUTY_W];

  lbkl_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // sequencer and state update
  always_comb begin
    state_nxt     = state_r;
    phase_nxt     = phase_r;
    count_nxt     = count_r;
    duty_nxt      = duty_r;
    en_nxt        = en_r;
    hold_nxt      = hold_r;
    level_nxt     = level_r;
    life_nxt      = life_r;
    cmd_nxt       = cmd_r;
    brth_nxt      = brth_r;
    out_valid_nxt = out_ready ? 1'b0 : out_valid_r;
    div_req.start    = 1'b0;
    div_req.dividend = op_dividend;
    div_req.divisor  = op_divisor;
    in_ready         = 1'b0;

    unique case (state_r)
      lbkl_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          div_req.start = 1'b1;
          cmd_nxt       = lbkl_pkg::lbkl_cmd_t'(in_cmd);
          brth_nxt      = tick_breathe;
          state_nxt     = lbkl_pkg::ST_DIV;
        end
      end
      lbkl_pkg::ST_DIV: begin
        if (div_rsp.done) begin
          state_nxt = lbkl_pkg::ST_UPDATE;
        end
      end
      lbkl_pkg::ST_UPDATE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          state_nxt     = lbkl_pkg::ST_IDLE;
          priority if (cmd_r == lbkl_pkg::CMD_KEY) begin
            // key press only counts in level mode below the top level
            if ((mode_r == lbkl_pkg::MODE_LEVEL) &&
                (level_r < LEVEL_W'(lbkl_pkg::LEVEL_MAX))) begin
              hold_nxt  = lbkl_pkg::PRESS_HOLD;
              level_nxt = level_inc[LEVEL_W-1:0];
              life_nxt  = quo[DUTY_W-1:0];
            end
          end else if (brth_r) begin
            // four-phase breathing ramp
            en_nxt    = 1'b1;
            count_nxt = count_inc;
            unique case (phase_r)
              lbkl_pkg::PH_RAMP_UP: begin
                duty_nxt = quo_hi ? lbkl_pkg::DUTY_FULL : quo[DUTY_W-1:0];
                if (count_r >= lim_br) begin
                  phase_nxt = lbkl_pkg::PH_HOLD_HIGH;
                end
              end
              lbkl_pkg::PH_RAMP_DOWN: begin
                duty_nxt = quo_hi ? '0 : lbkl_pkg::DUTY_FULL - quo[DUTY_W-1:0];
                if (count_r >= lim_dr) begin
                  phase_nxt = lbkl_pkg::PH_HOLD_LOW;
                end
              end
              lbkl_pkg::PH_HOLD_HIGH: begin
                if (count_r >= lim_dr) begin
                  count_nxt = COUNT_W'(1);
                  phase_nxt = lbkl_pkg::PH_RAMP_DOWN;
                end
              end
              lbkl_pkg::PH_HOLD_LOW: begin
                if (count_r >= lim_br) begin
                  count_nxt = COUNT_W'(1);
                  phase_nxt = lbkl_pkg::PH_RAMP_UP;
                end
              end
              default: begin
                phase_nxt = lbkl_pkg::PH_RAMP_UP;
              end
            endcase
          end else if (mode_r == lbkl_pkg::MODE_LEVEL) begin
            // level hold, then decay every dim-rate ticks
            en_nxt = 1'b1;
            priority if (hold_r != '0) begin
              hold_nxt = hold_r - 1'b1;
              duty_nxt = life_r;
            end else if (life_r != '0) begin
              if (count_inc >= COUNT_W'(dr_eff)) begin
                count_nxt = '0;
                life_nxt  = life_r - 1'b1;
                duty_nxt  = life_r - 1'b1;
                level_nxt = (quo >= DVD_W'(lbkl_pkg::LEVEL_MAX)) ? '0 :
                            LEVEL_W'(DVD_W'(lbkl_pkg::LEVEL_MAX) - quo);
              end else begin
                count_nxt = count_inc;
                duty_nxt  = life_r;
              end
            end else begin
              level_nxt = '0;
              count_nxt = '0;
              duty_nxt  = life_r;
            end
          end else begin
            // off, or idle time not reached
            duty_nxt  = '0;
            en_nxt    = 1'b0;
            count_nxt = '0;
            phase_nxt = lbkl_pkg::PH_RAMP_UP;
          end
        end
      end
      default: begin
        state_nxt = lbkl_pkg::ST_IDLE;
      end
    endcase
  end

  // configuration writes
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= lbkl_pkg::MODE_BREATHE;
      bright_r <= lbkl_pkg::BRIGHT_RST;
      dim_r    <= lbkl_pkg::DIM_RST;
    end else if (cfg_valid) begin
      unique case (lbkl_pkg::lbkl_cfg_idx_t'(cfg_index))
        lbkl_pkg::CFG_MODE:     mode_r   <= lbkl_pkg::lbkl_mode_t'(cfg_data[MODE_W_SEL-1:0]);
        lbkl_pkg::CFG_BRIGHTEN: bright_r <= cfg_data[RATE_W-1:0];
        lbkl_pkg::CFG_DIM:      dim_r    <= cfg_data[RATE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lbkl_pkg::ST_IDLE;
      phase_r     <= lbkl_pkg::PH_RAMP_UP;
      count_r     <= lbkl_pkg::COUNT_RESET;
      duty_r      <= '0;
      en_r        <= 1'b0;
      hold_r      <= '0;
      level_r     <= '0;
      life_r      <= '0;
      out_valid_r <= 1'b0;
      cmd_r       <= lbkl_pkg::CMD_TICK;
      brth_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      count_r     <= count_nxt;
      duty_r      <= duty_nxt;
      en_r        <= en_nxt;
      hold_r      <= hold_nxt;
      level_r     <= level_nxt;
      life_r      <= life_nxt;
      out_valid_r <= out_valid_nxt;
      cmd_r       <= cmd_nxt;
      brth_r      <= brth_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_pwm_duty   = duty_r;
  assign out_pwm_enable = en_r;

endmodule

@@ design/lbkl_chk.sv @@
module lbkl_chk (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [lbkl_pkg::DUTY_W-1:0] out_pwm_duty,
  input logic                        out_pwm_enable
);

  // a pending result holds until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_pwm_duty) &&
                                   $stable(out_pwm_enable)))
    else $error("result changed while stalled");

  // one transaction at a time: busy right after acceptance
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input taken again while busy");

  // a new result only appears at the end of a busy stretch
  a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared without work");

  // a disabled PWM always shows zero duty
  a_off_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_pwm_enable) |-> (out_pwm_duty == '0))
    else $error("non-zero duty with PWM disabled");

endmodule

bind led_breathing_and_keypress_level_top lbkl_chk u_lbkl_chk (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_pwm_duty   (out_pwm_duty),
  .out_pwm_enable (out_pwm_enable)
);

@@ sim/testbench.sv @@
`timescale 1ns / 100ps
module testbench;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int SETTLE_CYCLES  = 40;

  localparam int IDLE_W     = lbkl_pkg::IDLE_W;
  localparam int DUTY_W     = lbkl_pkg::DUTY_W;
  localparam int CFG_IDX_W  = lbkl_pkg::CFG_IDX_W;
  localparam int CFG_DATA_W = lbkl_pkg::CFG_DATA_W;
  localparam int RATE_W     = lbkl_pkg::RATE_W;
  localparam int COUNT_W    = lbkl_pkg::COUNT_W;
  localparam int HOLD_W     = lbkl_pkg::HOLD_W;
  localparam int LEVEL_W    = lbkl_pkg::LEVEL_W;
  localparam int MODE_W     = lbkl_pkg::MODE_W;
  localparam int LEVEL_MAX  = lbkl_pkg::LEVEL_MAX;
  localparam int LEVEL_STEP = lbkl_pkg::LEVEL_STEP;

  typedef struct {
    lbkl_pkg::lbkl_cmd_t cmd;
    logic [IDLE_W-1:0]   idle_ms;
  } backlight_event_t;

  typedef struct {
    logic [DUTY_W-1:0] duty;
    logic              enable;
  } backlight_out_t;

  logic                  clk            = 1'b0;
  logic                  rst_n          = 1'b0;
  logic                  cfg_valid      = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index      = '0;
  logic [CFG_DATA_W-1:0] cfg_data       = '0;
  logic                  in_valid       = 1'b0;
  logic                  in_ready;
  logic                  in_cmd         = 1'b0;
  logic [IDLE_W-1:0]     in_idle_ms     = '0;
  logic                  out_valid;
  logic                  out_ready      = 1'b0;
  logic [DUTY_W-1:0]     out_pwm_duty;
  logic                  out_pwm_enable;

  // handshake flags seen at the last rising edge
  logic in_taken  = 1'b0;
  logic cfg_taken = 1'b0;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int fail_count     = 0;
  int stall_cycles   = 0;

  backlight_event_t pending_events[$];
  backlight_out_t   duty_expected[$];

  // predictor copy of the registers and state
  lbkl_pkg::lbkl_mode_t  cur_mode   = lbkl_pkg::MODE_BREATHE;
  logic [RATE_W-1:0]     up_rate    = lbkl_pkg::BRIGHT_RST;
  logic [RATE_W-1:0]     down_rate  = lbkl_pkg::DIM_RST;
  logic [COUNT_W-1:0]    ramp_cnt   = lbkl_pkg::COUNT_RESET;
  lbkl_pkg::lbkl_phase_t ramp_ph    = lbkl_pkg::PH_RAMP_UP;
  logic [DUTY_W-1:0]     duty_now   = '0;
  logic                  enable_now = 1'b0;
  logic [HOLD_W-1:0]     hold_left  = '0;
  logic [LEVEL_W-1:0]    key_level  = '0;
  logic [DUTY_W-1:0]     life_left  = '0;

  led_breathing_and_keypress_level_top u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_cmd         (in_cmd),
    .in_idle_ms     (in_idle_ms),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_pwm_duty   (out_pwm_duty),
    .out_pwm_enable (out_pwm_enable)
  );

  // clock
  initial begin
    forever #4 clk = ~clk;
  end

  // saturating ramp counter step
  function automatic void bump_ramp();
    if (ramp_cnt != '1) ramp_cnt = ramp_cnt + 1'b1;
  endfunction

  // applies one tick or key press and returns the duty and enable after it
  function automatic backlight_out_t advance_backlight(backlight_event_t ev);
    int unsigned    up;
    int unsigned    down;
    int unsigned    quot;
    int unsigned    drop;
    backlight_out_t res;
    up   = (up_rate == 0) ? 1 : up_rate;
    down = (down_rate == 0) ? 1 : down_rate;
    if (ev.cmd == lbkl_pkg::CMD_KEY) begin
      // key press only counts in level mode and below the top level
      if (cur_mode == lbkl_pkg::MODE_LEVEL && key_level < LEVEL_MAX) begin
        hold_left = lbkl_pkg::PRESS_HOLD;
        key_level = key_level + 1'b1;
        life_left = DUTY_W'(255 * int'(key_level) / LEVEL_MAX);
      end
    end else if (cur_mode == lbkl_pkg::MODE_BREATHE ||
                 (cur_mode == lbkl_pkg::MODE_IDLE_BREATHE &&
                  ev.idle_ms > lbkl_pkg::IDLE_LIMIT)) begin
      // four-phase breathing cycle
      case (ramp_ph)
        lbkl_pkg::PH_RAMP_UP: begin
          quot     = ramp_cnt / up;
          duty_now = (quot > 255) ? lbkl_pkg::DUTY_FULL : DUTY_W'(quot);
          if (ramp_cnt >= 255 * up) ramp_ph = lbkl_pkg::PH_HOLD_HIGH;
        end
        lbkl_pkg::PH_RAMP_DOWN: begin
          quot     = ramp_cnt / down;
          duty_now = (quot > 255) ? '0 : DUTY_W'(255 - quot);
          if (ramp_cnt >= 255 * down) ramp_ph = lbkl_pkg::PH_HOLD_LOW;
        end
        lbkl_pkg::PH_HOLD_HIGH: begin
          if (ramp_cnt >= 255 * down) begin
            ramp_cnt = '0;
            ramp_ph  = lbkl_pkg::PH_RAMP_DOWN;
          end
        end
        default: begin
          if (ramp_cnt >= 255 * up) begin
            ramp_cnt = '0;
            ramp_ph  = lbkl_pkg::PH_RAMP_UP;
          end
        end
      endcase
      enable_now = 1'b1;
      bump_ramp();
    end else if (cur_mode == lbkl_pkg::MODE_LEVEL) begin
      // hold after a press, then decay the life one step per dim period
      if (hold_left != 0) begin
        hold_left = hold_left - 1'b1;
      end else if (life_left != 0) begin
        bump_ramp();
        if (ramp_cnt >= down) begin
          ramp_cnt  = '0;
          life_left = life_left - 1'b1;
          drop      = (255 - int'(life_left)) / LEVEL_STEP;
          key_level = (drop >= LEVEL_MAX) ? '0 : LEVEL_W'(LEVEL_MAX - drop);
        end
      end else begin
        key_level = '0;
        ramp_cnt  = '0;
      end
      duty_now   = life_left;
      enable_now = 1'b1;
    end else begin
      duty_now   = '0;
      enable_now = 1'b0;
      ramp_cnt   = '0;
      ramp_ph    = lbkl_pkg::PH_RAMP_UP;
    end
    res.duty   = duty_now;
    res.enable = enable_now;
    return res;
  endfunction

  // input driver
  always @(negedge clk) begin : in_driver
    backlight_event_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (pending_events.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        nxt = pending_events.pop_front();
        in_valid   <= 1'b1;
        in_cmd     <= nxt.cmd;
        in_idle_ms <= nxt.idle_ms;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result back-pressure
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // monitor: register writes, accepted items and results
  always @(posedge clk) begin : monitor
    backlight_event_t ev;
    backlight_out_t   exp_out;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        case (lbkl_pkg::lbkl_cfg_idx_t'(cfg_index))
          lbkl_pkg::CFG_MODE:     cur_mode = lbkl_pkg::lbkl_mode_t'(cfg_data[MODE_W-1:0]);
          lbkl_pkg::CFG_BRIGHTEN: up_rate = cfg_data;
          lbkl_pkg::CFG_DIM:      down_rate = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        ev.cmd     = lbkl_pkg::lbkl_cmd_t'(in_cmd);
        ev.idle_ms = in_idle_ms;
        duty_expected.push_back(advance_backlight(ev));
      end
      if (out_valid && out_ready) begin
        if (duty_expected.size() == 0) begin
          $error("unexpected result: pwm_duty %0d, pwm_enable %0d",
                 out_pwm_duty, out_pwm_enable);
          fail_count++;
        end else begin
          exp_out = duty_expected.pop_front();
          if (exp_out.duty !== out_pwm_duty) begin
            $error("pwm_duty mismatch: expected %0d, got %0d", exp_out.duty, out_pwm_duty);
            fail_count++;
          end
          if (exp_out.enable !== out_pwm_enable) begin
            $error("pwm_enable mismatch: expected %0d, got %0d",
                   exp_out.enable, out_pwm_enable);
            fail_count++;
          end
        end
      end
    end
    in_taken  <= in_valid && in_ready;
    cfg_taken <= cfg_valid && cfg_ready;
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      stall_cycles = 0;
    else
      stall_cycles = stall_cycles + 1;
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic logic [IDLE_W-1:0] rand_idle();
    case ($urandom_range(3))
      0:       return IDLE_W'($urandom_range(995, 1005));
      1:       return $urandom_range(1) ? '1 : '0;
      default: return IDLE_W'($urandom_range(32767));
    endcase
  endfunction

  function automatic logic [RATE_W-1:0] rand_rate();
    case ($urandom_range(3))
      0:       return 8'd255;
      1:       return RATE_W'($urandom_range(2));
      default: return RATE_W'($urandom_range(255));
    endcase
  endfunction

  task automatic queue_event(input lbkl_pkg::lbkl_cmd_t cmd, input logic [IDLE_W-1:0] idle_ms);
    backlight_event_t ev;
    ev.cmd     = cmd;
    ev.idle_ms = idle_ms;
    pending_events.push_back(ev);
  endtask

  // n events with random idle time, key presses at the given percentage
  task automatic queue_ticks(input int n, input int key_pct);
    lbkl_pkg::lbkl_cmd_t cmd;
    for (int i = 0; i < n; i++) begin
      cmd = ($urandom_range(99) < key_pct) ? lbkl_pkg::CMD_KEY : lbkl_pkg::CMD_TICK;
      queue_event(cmd, rand_idle());
    end
  endtask

  // sender holds off until every outstanding result has been taken
  task automatic wait_drained();
    do @(posedge clk);
    while (pending_events.size() != 0 || in_valid || duty_expected.size() != 0);
  endtask

  task automatic write_reg(input lbkl_pkg::lbkl_cfg_idx_t idx,
                           input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(negedge clk);
    while (!cfg_taken);
    cfg_valid <= 1'b0;
  endtask

  task automatic configure(input lbkl_pkg::lbkl_mode_t mode, input logic [RATE_W-1:0] up,
                           input logic [RATE_W-1:0] down);
    write_reg(lbkl_pkg::CFG_MODE, CFG_DATA_W'(mode));
    write_reg(lbkl_pkg::CFG_BRIGHTEN, up);
    write_reg(lbkl_pkg::CFG_DIM, down);
  endtask

  task automatic set_idling(input int sel);
    case (sel % 4)
      0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1:       begin send_idle_pct = 63; recv_stall_pct = 0;  end
      2:       begin send_idle_pct = 0;  recv_stall_pct = 63; end
      default: begin send_idle_pct = 38; recv_stall_pct = 38; end
    endcase
  endtask

  // stimulus sequence
  initial begin : stimulus
    lbkl_pkg::lbkl_mode_t mode;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    set_idling(0);

    // reset settings: ticks at idle extremes, key press outside level mode
    queue_event(lbkl_pkg::CMD_TICK, '0);
    queue_event(lbkl_pkg::CMD_TICK, '1);
    queue_event(lbkl_pkg::CMD_KEY, '0);
    wait_drained();
    // off mode
    write_reg(lbkl_pkg::CFG_MODE, CFG_DATA_W'(lbkl_pkg::MODE_OFF));
    queue_event(lbkl_pkg::CMD_TICK, IDLE_W'(12345));
    wait_drained();
    // breathing when idle: threshold not reached, just passed, far past
    write_reg(lbkl_pkg::CFG_MODE, CFG_DATA_W'(lbkl_pkg::MODE_IDLE_BREATHE));
    queue_event(lbkl_pkg::CMD_TICK, lbkl_pkg::IDLE_LIMIT);
    queue_event(lbkl_pkg::CMD_TICK, lbkl_pkg::IDLE_LIMIT + 1'b1);
    queue_event(lbkl_pkg::CMD_TICK, '1);
    wait_drained();
    // zero rates behave as one
    configure(lbkl_pkg::MODE_BREATHE, '0, '0);
    queue_event(lbkl_pkg::CMD_TICK, '0);
    queue_event(lbkl_pkg::CMD_TICK, IDLE_W'(21845));
    wait_drained();
    // level mode: tick with no life, two presses, then a held tick
    write_reg(lbkl_pkg::CFG_MODE, CFG_DATA_W'(lbkl_pkg::MODE_LEVEL));
    queue_event(lbkl_pkg::CMD_TICK, '0);
    queue_event(lbkl_pkg::CMD_KEY, '0);
    queue_event(lbkl_pkg::CMD_KEY, '1);
    queue_event(lbkl_pkg::CMD_TICK, IDLE_W'(16383));
    wait_drained();

    // full breathing cycle at the fastest rates, key presses as noise
    set_idling(1);
    configure(lbkl_pkg::MODE_BREATHE, 8'd1, 8'd1);
    queue_ticks(545, 5);
    wait_drained();

    // climb to the top level and beyond, hold, decay from full to zero as the level clamps
    set_idling(2);
    configure(lbkl_pkg::MODE_LEVEL, rand_rate(), RATE_W'($urandom_range(1)));
    for (int i = 0; i < 22; i++) queue_event(lbkl_pkg::CMD_KEY, rand_idle());
    queue_ticks(790, 0);
    queue_ticks(20, 30);
    wait_drained();

    // rate changes part way through the ramps push the duty past its limits
    set_idling(3);
    write_reg(lbkl_pkg::CFG_MODE, CFG_DATA_W'(lbkl_pkg::MODE_OFF));
    queue_event(lbkl_pkg::CMD_TICK, rand_idle());
    wait_drained();
    configure(lbkl_pkg::MODE_BREATHE, 8'd2, 8'd1);
    queue_ticks(260, 0);
    wait_drained();
    write_reg(lbkl_pkg::CFG_BRIGHTEN, 8'd1);
    queue_ticks(2, 0);
    wait_drained();
    write_reg(lbkl_pkg::CFG_DIM, 8'd2);
    queue_ticks(260, 0);
    wait_drained();
    write_reg(lbkl_pkg::CFG_DIM, 8'd1);
    queue_ticks(3, 0);
    wait_drained();

    // short runs under random settings, slowest rates first
    for (int j = 0; j < 5; j++) begin
      set_idling(j);
      if (j == 0) begin
        configure(lbkl_pkg::MODE_BREATHE, 8'd255, 8'd255);
        mode = lbkl_pkg::MODE_BREATHE;
      end else begin
        mode = lbkl_pkg::lbkl_mode_t'($urandom_range(3));
        configure(mode, rand_rate(), rand_rate());
      end
      queue_ticks(16, (mode == lbkl_pkg::MODE_LEVEL) ? 30 : 10);
      wait_drained();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0 && duty_expected.size() == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
